### hw/rtl/vdt_pkg.sv
`default_nettype none

package vdt_pkg;

    // Sine table entry: magnitude 0..32767
    localparam int ENTRY_W = 15;
    localparam int SINE_W  = 16;

    // Quarter wave angle pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Taylor series divisors (2n)(2n+1) for n = 1..7
    localparam int TAYLOR_TERMS = 7;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int STEP_W      = 32;
    localparam int AMP_W       = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_LFO_STEP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_STEP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_STEP  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_STEP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE   = 3'd4;

    localparam logic [STEP_W-1:0] LFO_STEP_RST    = 32'd48695;
    localparam logic [STEP_W-1:0] CENTER_STEP_RST = 32'd42852282;
    localparam logic [STEP_W-1:0] DEPTH_STEP_RST  = 32'd486957;
    localparam logic [STEP_W-1:0] TONE_STEP_RST   = 32'd42852282;
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST   = 15'd15000;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LFO  = 6'b000010,
        S_CAR  = 6'b000100,
        S_TONE = 6'b001000,
        S_MIX  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/vdt_sine_rom.sv
`default_nettype none

module vdt_sine_rom #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic [SINE_TABLE_BITS-1:0]        addr,
    output logic signed [vdt_pkg::SINE_W-1:0]      sine
);
    import vdt_pkg::*;

    localparam int K_W   = SINE_TABLE_BITS - 2;
    localparam int Q     = 1 << K_W;
    localparam int IDX_W = K_W + 1;

    // Quarter wave table, built at elaboration from the Taylor series in Q30
    function automatic logic [(Q+1)*ENTRY_W-1:0] build_rom();
        logic [(Q+1)*ENTRY_W-1:0] bits;
        logic [63:0]              x;
        logic [63:0]              x2;
        logic [63:0]              term;
        logic signed [63:0]       sum;
        logic [63:0]              v;
        bits = '0;
        for (int k = 0; k <= Q; k++) begin
            x    = (64'(k) * HALF_PI_Q30) >> K_W;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
                if ((n % 2) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = '0;
            v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767)
                v = 64'd32767;
            bits[k*ENTRY_W +: ENTRY_W] = v[ENTRY_W-1:0];
        end
        return bits;
    endfunction

    localparam logic [(Q+1)*ENTRY_W-1:0] ROM_BITS = build_rom();

    logic [1:0]         quad;
    logic [K_W-1:0]     k;
    logic [IDX_W-1:0]   rom_idx;
    logic [ENTRY_W-1:0] entry_reg;
    logic               neg_reg;

    // Quadrant folding: odd quadrants read the table mirrored
    assign quad    = addr[SINE_TABLE_BITS-1 -: 2];
    assign k       = addr[K_W-1:0];
    assign rom_idx = quad[0] ? (IDX_W'(Q) - IDX_W'(k)) : IDX_W'(k);

    // Registered table read
    always_ff @(posedge clk)
    begin
        entry_reg <= ROM_BITS[rom_idx*ENTRY_W +: ENTRY_W];
        neg_reg   <= quad[1];
    end

    // Lower half of the cycle is negated
    assign sine = neg_reg ? -$signed({1'b0, entry_reg}) : $signed({1'b0, entry_reg});

endmodule

`default_nettype wire

### hw/rtl/vdt_mul.sv
`default_nettype none

module vdt_mul (
    input  wire logic                                 clk,
    input  wire logic                                 load,
    input  wire logic signed [vdt_pkg::MUL_A_W-1:0]   a,
    input  wire logic signed [vdt_pkg::MUL_B_W-1:0]   b,
    output logic signed [vdt_pkg::MUL_P_W-1:0]        prod
);
    import vdt_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    // Signed multiply, product held until the next load
    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

### hw/rtl/vibrato_dual_tone_generator_unit.sv
`default_nettype none

// Vibrato dual-tone generator: LFO-modulated sine carrier plus a fixed sine tone.
// Input channel (in_valid / in_stall / sample_request): each transfer with
// sample_request = 1 produces one signed 16-bit sample on the output channel
// (out_valid / out_stall / sample); a transfer with sample_request = 0 does nothing.
// The sequencer steps through S_LFO, S_CAR, S_TONE, S_MIX and S_OUT; in_stall is high
// in every state but S_IDLE, so no new request is taken before the sample is loaded.
// The steps come from walking three oscillators through one registered sine ROM
// and one shared 33x18 multiplier (depth swing, then gain).
// A new request may be taken while a finished sample waits; if out_stall holds
// the output register full, the sequencer waits in its last step until it drains.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; index 0 lfo_step, 1 vibrato_center_step, 2 vibrato_depth_step,
// 3 tone_step, 4 amplitude. Other indexes are ignored. Write only while idle.
// Reset (rst_n low, asynchronous) restores the default tuning words and gain and
// clears the three phase accumulators and the output valid flag.
module vibrato_dual_tone_generator_unit #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 sample_request,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [15:0]                        sample,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [vdt_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [vdt_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import vdt_pkg::*;

    state_t state_reg, state_next;

    logic [STEP_W-1:0] lfo_step_reg;
    logic [STEP_W-1:0] center_step_reg;
    logic [STEP_W-1:0] depth_step_reg;
    logic [STEP_W-1:0] tone_step_reg;
    logic [AMP_W-1:0]  amplitude_reg;

    logic [PHASE_BITS-1:0] lfo_phase_reg;
    logic [PHASE_BITS-1:0] carrier_phase_reg;
    logic [PHASE_BITS-1:0] tone_phase_reg;

    logic                     out_valid_reg;
    logic signed [15:0]       sample_reg;
    logic signed [SINE_W-1:0] car_sine_reg;

    logic [SINE_TABLE_BITS-1:0] rom_addr;
    logic signed [SINE_W-1:0]   rom_sine;

    logic                      mul_load;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_prod;

    logic signed [63:0]        swing64;
    logic [63:0]               inc64;
    logic [63:0]               lfo_sum64;
    logic [63:0]               tone_sum64;
    logic signed [SINE_W:0]    mix_sum;
    logic signed [MUL_P_W-1:0] mix_shift;
    logic                      start;
    logic                      out_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign start     = in_valid && !in_stall && sample_request;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_LFO;
            S_LFO:   state_next = S_CAR;
            S_CAR:   state_next = S_TONE;
            S_TONE:  state_next = S_MIX;
            S_MIX:   state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ROM address: one oscillator per step
    always_comb
    begin
        unique case (state_reg)
            S_CAR:   rom_addr = carrier_phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
            S_TONE:  rom_addr = tone_phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
            default: rom_addr = lfo_phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
        endcase
    end

    vdt_sine_rom #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .sine (rom_sine)
    );

    // Multiplier operands: depth x LFO sine, then (carrier + tone) x amplitude
    assign mix_sum = (SINE_W+1)'(car_sine_reg) + (SINE_W+1)'(rom_sine);

    always_comb
    begin
        mul_load = 1'b0;
        mul_a    = $signed({1'b0, depth_step_reg});
        mul_b    = MUL_B_W'(rom_sine);
        unique case (state_reg)
            S_CAR:
            begin
                mul_load = 1'b1;
            end
            S_MIX:
            begin
                mul_load = 1'b1;
                mul_a    = MUL_A_W'(mix_sum);
                mul_b    = $signed({{(MUL_B_W-AMP_W){1'b0}}, amplitude_reg});
            end
            default:
            begin
                mul_load = 1'b0;
            end
        endcase
    end

    vdt_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // Carrier increment: centre plus floored swing, wrapped to the phase width
    assign swing64    = 64'(mul_prod) >>> 15;
    assign inc64      = 64'(center_step_reg) + $unsigned(swing64) + 64'(carrier_phase_reg);
    assign lfo_sum64  = 64'(lfo_step_reg) + 64'(lfo_phase_reg);
    assign tone_sum64 = 64'(tone_step_reg) + 64'(tone_phase_reg);
    assign mix_shift  = mul_prod >>> 16;

    // Control, configuration and phase state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            lfo_step_reg      <= LFO_STEP_RST;
            center_step_reg   <= CENTER_STEP_RST;
            depth_step_reg    <= DEPTH_STEP_RST;
            tone_step_reg     <= TONE_STEP_RST;
            amplitude_reg     <= AMPLITUDE_RST;
            lfo_phase_reg     <= '0;
            carrier_phase_reg <= '0;
            tone_phase_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_LFO_STEP:    lfo_step_reg    <= cfg_data[STEP_W-1:0];
                    REG_CENTER_STEP: center_step_reg <= cfg_data[STEP_W-1:0];
                    REG_DEPTH_STEP:  depth_step_reg  <= cfg_data[STEP_W-1:0];
                    REG_TONE_STEP:   tone_step_reg   <= cfg_data[STEP_W-1:0];
                    REG_AMPLITUDE:   amplitude_reg   <= cfg_data[AMP_W-1:0];
                    default:         ;
                endcase
            end

            // Phases advance once all three sines are read
            if (state_reg == S_MIX)
            begin
                lfo_phase_reg     <= lfo_sum64[PHASE_BITS-1:0];
                carrier_phase_reg <= inc64[PHASE_BITS-1:0];
                tone_phase_reg    <= tone_sum64[PHASE_BITS-1:0];
            end

            // Output valid: set on load, cleared on transfer
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_TONE)
            car_sine_reg <= rom_sine;
        if (state_reg == S_OUT && out_free)
            sample_reg <= mix_shift[15:0];
    end

endmodule

`default_nettype wire
